// ===== rtl/pcur_pkg.sv =====
// ----------------------------------------------------------------------------
// pcur_pkg
// Shared types and constants for the pixel channel unpack and remap block.
// ----------------------------------------------------------------------------
package pcur_pkg;

	// payload widths
	localparam int WORD_W     = 64;
	localparam int CHAN_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int SEL_W      = 2;
	localparam int SLOT_W     = 8;
	localparam int CTL_W      = 14;
	localparam int MASK_W     = 8;
	localparam int SHIFT_W    = 6;
	localparam int SHIFT_LSB  = 8;
	localparam int NUM_LANES  = 4;
	localparam int MODE_W     = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// item kinds
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_UNPACK = 1'b1;

	// channel layout; the unlisted code behaves as four channels
	typedef enum logic [MODE_W-1:0] {
		MODE_ONE  = 2'd0,
		MODE_TWO  = 2'd1,
		MODE_FOUR = 2'd2
	} chan_mode_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_MODE = 3'd0,
		REG_DEEP_COLOR   = 3'd1,
		REG_FIELD_CTL_0  = 3'd2,
		REG_FIELD_CTL_1  = 3'd3,
		REG_FIELD_CTL_2  = 3'd4,
		REG_FIELD_CTL_3  = 3'd5
	} cfg_reg_t;

	// output formatting controls handed to the merge stage
	typedef struct packed {
		chan_mode_t mode;
		logic       deep;
	} view_cfg_t;

	// is output lane k populated in this layout
	function automatic logic lane_active(chan_mode_t mode, int k);
		logic act;
		unique case (mode)
			MODE_ONE: act = (k == 0);
			MODE_TWO: act = (k < 2);
			default:  act = 1'b1;
		endcase
		return act;
	endfunction

endpackage

// ===== rtl/pcur_in_if.sv =====
// ----------------------------------------------------------------------------
// pcur_in_if
// Input item channel: table writes and pixel words, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcur_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [pcur_pkg::WORD_W-1:0]   packed_word;
	logic [pcur_pkg::SEL_W-1:0]    table_select;
	logic [pcur_pkg::SLOT_W-1:0]   table_slot;
	logic [pcur_pkg::CHAN_W-1:0]   table_word;

	modport source (output valid, action, packed_word, table_select, table_slot, table_word,
		input ready);
	modport sink (input valid, action, packed_word, table_select, table_slot, table_word,
		output ready);
endinterface

// ===== rtl/pcur_out_if.sv =====
// ----------------------------------------------------------------------------
// pcur_out_if
// Result item channel: four unpacked channel values, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcur_out_if;
	logic                          valid;
	logic                          ready;
	logic [pcur_pkg::CHAN_W-1:0]   chan_out_0;
	logic [pcur_pkg::CHAN_W-1:0]   chan_out_1;
	logic [pcur_pkg::CHAN_W-1:0]   chan_out_2;
	logic [pcur_pkg::CHAN_W-1:0]   chan_out_3;

	modport source (output valid, chan_out_0, chan_out_1, chan_out_2, chan_out_3,
		input ready);
	modport sink (input valid, chan_out_0, chan_out_1, chan_out_2, chan_out_3,
		output ready);
endinterface

// ===== rtl/pcur_lane.sv =====
// ----------------------------------------------------------------------------
// pcur_lane
// One channel lane: field extract from the pixel word and scale table lookup.
// ----------------------------------------------------------------------------
module pcur_lane #(
	parameter int INDEX_BITS = 8
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [pcur_pkg::SLOT_W-1:0]    wr_slot,
	input  logic [pcur_pkg::CHAN_W-1:0]    wr_data,
	input  logic                           rd_en,
	input  logic [pcur_pkg::WORD_W-1:0]    word,
	input  logic [pcur_pkg::CTL_W-1:0]     ctl,
	output logic [pcur_pkg::CHAN_W-1:0]    rd_data
);

	localparam int DEPTH   = 1 << INDEX_BITS;
	localparam int SLOT_EW = INDEX_BITS + pcur_pkg::SLOT_W;
	localparam int MASK_EW = INDEX_BITS + pcur_pkg::MASK_W;

	logic [pcur_pkg::CHAN_W-1:0]  mem_q [DEPTH];
	logic [pcur_pkg::CHAN_W-1:0]  rd_data_q;
	logic [pcur_pkg::SHIFT_W-1:0] shift;
	logic [pcur_pkg::WORD_W-1:0]  shifted;
	logic [MASK_EW-1:0]           mask_ext;
	logic [SLOT_EW-1:0]           slot_ext;
	logic [INDEX_BITS-1:0]        rd_idx;
	logic [INDEX_BITS-1:0]        wr_idx;

	// index = (word >> shift) & mask, limited to the table size
	always_comb begin
		shift    = ctl[pcur_pkg::SHIFT_LSB +: pcur_pkg::SHIFT_W];
		shifted  = word >> shift;
		mask_ext = MASK_EW'(ctl[pcur_pkg::MASK_W-1:0]);
		rd_idx   = shifted[INDEX_BITS-1:0] & mask_ext[INDEX_BITS-1:0];
		slot_ext = SLOT_EW'(wr_slot);
		wr_idx   = slot_ext[INDEX_BITS-1:0];
	end

	// scale table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/pcur_merge.sv =====
// ----------------------------------------------------------------------------
// pcur_merge
// Combines the lane lookups into one result item and holds it in the
// output register until the sink takes it.
// ----------------------------------------------------------------------------
module pcur_merge (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                in_valid,
	input  logic [pcur_pkg::NUM_LANES-1:0][pcur_pkg::CHAN_W-1:0] lane_data,
	input  pcur_pkg::view_cfg_t                                 view_cfg,
	output logic                                                advance,
	pcur_out_if.source                                          pix_out
);

	logic                                                 valid_q;
	logic [pcur_pkg::NUM_LANES-1:0][pcur_pkg::CHAN_W-1:0] merged;
	logic [pcur_pkg::NUM_LANES-1:0][pcur_pkg::CHAN_W-1:0] chan_q;

	// output register is free when empty or being drained
	assign advance = !valid_q || pix_out.ready;

	// layout zeroing and 8-bit narrowing per lane
	always_comb begin
		for (int k = 0; k < pcur_pkg::NUM_LANES; k++) begin
			if (!pcur_pkg::lane_active(view_cfg.mode, k)) begin
				merged[k] = '0;
			end else if (view_cfg.deep) begin
				merged[k] = lane_data[k];
			end else begin
				merged[k] = pcur_pkg::CHAN_W'(lane_data[k][pcur_pkg::BYTE_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			chan_q <= merged;
		end
	end

	assign pix_out.valid      = valid_q;
	assign pix_out.chan_out_0 = chan_q[0];
	assign pix_out.chan_out_1 = chan_q[1];
	assign pix_out.chan_out_2 = chan_q[2];
	assign pix_out.chan_out_3 = chan_q[3];

endmodule

// ===== rtl/pixel_channel_unpack_remap.sv =====
// ----------------------------------------------------------------------------
// pixel_channel_unpack_remap
// Packed pixel channel extract with per-channel scale tables, one lane per
// channel and a merge stage that formats the result item.
// Pipeline: a pixel item is looked up into the lane read registers when it is
// accepted, then moves into the merge output register once that register is free.
// Throughput: one item per cycle while the output is not stalled; the tables are
// single-port-write RAMs with a registered read, so write and pixel items flow alike.
// Reset: config registers go to their defaults and the pipeline empties;
// table contents stay undefined until written, and there is no clearing pass.
// ----------------------------------------------------------------------------
module pixel_channel_unpack_remap #(
	parameter int INDEX_BITS = 8,
	parameter int CHANNELS   = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pcur_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcur_pkg::CFG_DATA_W-1:0]   cfg_data,
	pcur_in_if.sink                           pix_in,
	pcur_out_if.source                        pix_out
);

	pcur_pkg::chan_mode_t                                 channel_mode_q;
	logic                                                 deep_color_q;
	logic [pcur_pkg::CTL_W-1:0]                           field_ctl_q [pcur_pkg::NUM_LANES];
	logic                                                 valid_s1;
	logic                                                 en_s1;
	logic                                                 en_out;
	logic                                                 accept;
	logic                                                 tbl_we;
	logic [pcur_pkg::NUM_LANES-1:0][pcur_pkg::CHAN_W-1:0] lane_data;
	pcur_pkg::view_cfg_t                                  view_cfg;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_mode_q <= pcur_pkg::MODE_FOUR;
			deep_color_q   <= 1'b0;
			for (int k = 0; k < pcur_pkg::NUM_LANES; k++) begin
				field_ctl_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcur_pkg::REG_CHANNEL_MODE: begin
					channel_mode_q <= pcur_pkg::chan_mode_t'(cfg_data[pcur_pkg::MODE_W-1:0]);
				end
				pcur_pkg::REG_DEEP_COLOR:  deep_color_q   <= cfg_data[0];
				pcur_pkg::REG_FIELD_CTL_0: field_ctl_q[0] <= cfg_data;
				pcur_pkg::REG_FIELD_CTL_1: field_ctl_q[1] <= cfg_data;
				pcur_pkg::REG_FIELD_CTL_2: field_ctl_q[2] <= cfg_data;
				pcur_pkg::REG_FIELD_CTL_3: field_ctl_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves when empty or when the output register frees
	assign en_s1        = !valid_s1 || en_out;
	assign pix_in.ready = en_s1;
	assign accept       = pix_in.valid && en_s1;
	assign tbl_we       = accept && (pix_in.action == pcur_pkg::ACT_WRITE);

	// only pixel items travel on; table writes end at the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= accept && (pix_in.action == pcur_pkg::ACT_UNPACK);
		end
	end

	// channel lanes; missing channels read as zero
	for (genvar c = 0; c < pcur_pkg::NUM_LANES; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			pcur_lane #(
				.INDEX_BITS(INDEX_BITS)
			) u_lane (
				.clk     (clk),
				.wr_en   (tbl_we && (pix_in.table_select == pcur_pkg::SEL_W'(c))),
				.wr_slot (pix_in.table_slot),
				.wr_data (pix_in.table_word),
				.rd_en   (en_s1),
				.word    (pix_in.packed_word),
				.ctl     (field_ctl_q[c]),
				.rd_data (lane_data[c])
			);
		end else begin : g_off
			assign lane_data[c] = '0;
		end
	end

	assign view_cfg.mode = channel_mode_q;
	assign view_cfg.deep = deep_color_q;

	// merge and output register
	pcur_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.lane_data (lane_data),
		.view_cfg  (view_cfg),
		.advance   (en_out),
		.pix_out   (pix_out)
	);

	// a table write never enters the result pipeline
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pix_in.action == pcur_pkg::ACT_WRITE) |=> !valid_s1)
		else $error("table write produced a pipeline item");

	// every accepted pixel item reaches stage 1
	a_unpack_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pix_in.action == pcur_pkg::ACT_UNPACK) |=> valid_s1)
		else $error("pixel item lost before stage 1");

	// lookup data holds while stage 1 is stalled
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !en_out) |=> $stable(lane_data))
		else $error("lane data changed under stall");

endmodule
